// ===== sv/vpr_pkg.sv =====
// vpr_pkg: shared types, widths and constants of the visibility phase rotator.
// No dependencies; all other files use it, the design files by scoped names.

package vpr_pkg;

  localparam int AMP_WIDTH     = 24;
  localparam int COORD_WIDTH   = 32;
  localparam int CORDIC_STAGES = 24;
  localparam int GUARD         = 8;

  localparam int OFFSET_WIDTH = 32;
  localparam int PHASE_WIDTH  = 32;
  localparam int COORD_FRAC   = COORD_WIDTH - 16;
  localparam int PHASE_FB     = COORD_FRAC + 30;
  localparam int PROD_WIDTH   = COORD_WIDTH + OFFSET_WIDTH;

  // rotator datapath: amplitude, guard bits and headroom for growth
  localparam int XW        = AMP_WIDTH + GUARD + 3;
  localparam int PRE_WIDTH = AMP_WIDTH + 1;

  localparam int KINV_WIDTH = 31;
  localparam logic signed [KINV_WIDTH-1:0] KINV_Q30 = 31'sd652032874;
  localparam int GAIN_SHIFT      = 30 - GUARD;
  localparam int GAIN_PROD_WIDTH = PRE_WIDTH + KINV_WIDTH;

  localparam logic signed [XW-1:0] RND_HALF = XW'(2 ** (GUARD - 1));
  localparam logic signed [XW-1:0] SAT_HI   = XW'(2 ** (AMP_WIDTH - 1) - 1);
  localparam logic signed [XW-1:0] SAT_LO   = ~SAT_HI;

  localparam int STAGE_IDX_W = 5;
  localparam int ATAN_DEPTH  = 32;

  // arctangent of 2^-i in units of 2^-32 turn
  localparam logic [PHASE_WIDTH-1:0] ATAN_TURNS [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_L = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_M = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_N = 2'd2;

  localparam logic [1:0] QUAD_ZERO  = 2'd0;
  localparam logic [1:0] QUAD_ONE   = 2'd1;
  localparam logic [1:0] QUAD_TWO   = 2'd2;
  localparam logic [1:0] QUAD_THREE = 2'd3;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] coord_u;
    logic signed [COORD_WIDTH-1:0] coord_v;
    logic signed [COORD_WIDTH-1:0] coord_w;
    logic signed [AMP_WIDTH-1:0]   amp_re;
    logic signed [AMP_WIDTH-1:0]   amp_im;
    logic                          last_in;
  } vpr_in_t;

  typedef struct packed {
    logic signed [AMP_WIDTH-1:0] rot_re;
    logic signed [AMP_WIDTH-1:0] rot_im;
    logic                        last_out;
  } vpr_out_t;

  typedef struct packed {
    logic                          vld;
    logic signed [XW-1:0]          x;
    logic signed [XW-1:0]          y;
    logic signed [PHASE_WIDTH-1:0] z;
    logic                          last;
  } cordic_t;

endpackage

// ===== sv/vpr_in_if.sv =====
// vpr_in_if: request channel carrying one visibility (valid/ready handshake).
// Depends on vpr_pkg for the payload type.

interface vpr_in_if;
  logic             valid;
  logic             ready;
  vpr_pkg::vpr_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/vpr_out_if.sv =====
// vpr_out_if: result channel carrying one rotated amplitude (valid/ready handshake).
// Depends on vpr_pkg for the payload type.

interface vpr_out_if;
  logic              valid;
  logic              ready;
  vpr_pkg::vpr_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/vpr_phase.sv =====
// vpr_phase: front end of the rotator: phase products, phase sum, quadrant
// pre-rotation and gain compensation, three register stages. Uses vpr_pkg.

module vpr_phase (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    en,
  input  logic                                    in_vld,
  input  vpr_pkg::vpr_in_t                        in_data,
  input  logic signed [vpr_pkg::OFFSET_WIDTH-1:0] offset_l,
  input  logic signed [vpr_pkg::OFFSET_WIDTH-1:0] offset_m,
  input  logic signed [vpr_pkg::OFFSET_WIDTH-1:0] offset_n,
  output vpr_pkg::cordic_t                        stage_out
);

  // stage 1: products
  logic                                  vld1_r;
  logic signed [vpr_pkg::PROD_WIDTH-1:0] prod_u_r, prod_v_r, prod_w_r;
  logic signed [vpr_pkg::AMP_WIDTH-1:0]  re1_r, im1_r;
  logic                                  last1_r;

  // stage 2: phase
  logic                                  vld2_r;
  logic [vpr_pkg::PHASE_WIDTH-1:0]       phase2_r;
  logic signed [vpr_pkg::AMP_WIDTH-1:0]  re2_r, im2_r;
  logic                                  last2_r;

  // stage 3: gain compensated vector and residual angle
  logic                                   vld3_r;
  logic signed [vpr_pkg::XW-1:0]          x3_r, y3_r;
  logic signed [vpr_pkg::PHASE_WIDTH-1:0] z3_r;
  logic                                   last3_r;

  logic [vpr_pkg::PROD_WIDTH-1:0]                       sum_nxt;
  logic [vpr_pkg::PROD_WIDTH+vpr_pkg::PHASE_WIDTH-1:0]  sum_ext;
  logic [vpr_pkg::PHASE_WIDTH-1:0]                      phase_nxt;
  logic [vpr_pkg::PHASE_WIDTH-1:0]                      qsum;
  logic [1:0]                                           quad;
  logic [vpr_pkg::PHASE_WIDTH-1:0]                      resid;
  logic signed [vpr_pkg::PRE_WIDTH-1:0]                 re_e, im_e, xp, yp;
  logic signed [vpr_pkg::GAIN_PROD_WIDTH-1:0]           gx, gy, gx_sh, gy_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_u_r <= $signed(in_data.coord_u) * offset_l;
      prod_v_r <= $signed(in_data.coord_v) * offset_m;
      prod_w_r <= $signed(in_data.coord_w) * offset_n;
      re1_r    <= in_data.amp_re;
      im1_r    <= in_data.amp_im;
      last1_r  <= in_data.last_in;
    end
  end

  // keep the 32 bits just below the binary point, zero padded for narrow coords
  always_comb begin
    sum_nxt   = prod_u_r + prod_v_r + prod_w_r;
    sum_ext   = {sum_nxt, {vpr_pkg::PHASE_WIDTH{1'b0}}};
    phase_nxt = sum_ext[vpr_pkg::PHASE_FB+vpr_pkg::PHASE_WIDTH-1 -: vpr_pkg::PHASE_WIDTH];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phase2_r <= phase_nxt;
      re2_r    <= re1_r;
      im2_r    <= im1_r;
      last2_r  <= last1_r;
    end
  end

  // nearest quarter turn, residual in [-1/8, 1/8) turn
  always_comb begin
    qsum  = phase2_r + 32'h2000_0000;
    quad  = qsum[vpr_pkg::PHASE_WIDTH-1 -: 2];
    resid = phase2_r - {quad, {(vpr_pkg::PHASE_WIDTH-2){1'b0}}};
    re_e  = {re2_r[vpr_pkg::AMP_WIDTH-1], re2_r};
    im_e  = {im2_r[vpr_pkg::AMP_WIDTH-1], im2_r};
    case (quad)
      vpr_pkg::QUAD_ZERO: begin
        xp = re_e;
        yp = im_e;
      end
      vpr_pkg::QUAD_ONE: begin
        xp = -im_e;
        yp = re_e;
      end
      vpr_pkg::QUAD_TWO: begin
        xp = -re_e;
        yp = -im_e;
      end
      vpr_pkg::QUAD_THREE: begin
        xp = im_e;
        yp = -re_e;
      end
      default: begin
        xp = re_e;
        yp = im_e;
      end
    endcase
    gx    = xp * vpr_pkg::KINV_Q30;
    gy    = yp * vpr_pkg::KINV_Q30;
    gx_sh = gx >>> vpr_pkg::GAIN_SHIFT;
    gy_sh = gy >>> vpr_pkg::GAIN_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3_r    <= gx_sh[vpr_pkg::XW-1:0];
      y3_r    <= gy_sh[vpr_pkg::XW-1:0];
      z3_r    <= $signed(resid);
      last3_r <= last2_r;
    end
  end

  assign stage_out = '{vld: vld3_r, x: x3_r, y: y3_r, z: z3_r, last: last3_r};

endmodule

// ===== sv/vpr_cordic_cell.sv =====
// vpr_cordic_cell: one CORDIC rotation step with its own pipeline register.
// Uses vpr_pkg for the stage type and the arctangent table.

module vpr_cordic_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic [vpr_pkg::STAGE_IDX_W-1:0]   stage_idx,
  input  vpr_pkg::cordic_t                  cell_in,
  output vpr_pkg::cordic_t                  cell_out
);

  logic                                   vld_r;
  logic signed [vpr_pkg::XW-1:0]          x_r, y_r;
  logic signed [vpr_pkg::PHASE_WIDTH-1:0] z_r;
  logic                                   last_r;

  logic signed [vpr_pkg::XW-1:0]          xs, ys, x_nxt, y_nxt;
  logic signed [vpr_pkg::PHASE_WIDTH-1:0] z_nxt;
  logic [vpr_pkg::PHASE_WIDTH-1:0]        atan;

  // stage_idx is tied to a constant, so the shifts collapse to wiring
  always_comb begin
    xs   = $signed(cell_in.x) >>> stage_idx;
    ys   = $signed(cell_in.y) >>> stage_idx;
    atan = vpr_pkg::ATAN_TURNS[stage_idx];
    if (!cell_in.z[vpr_pkg::PHASE_WIDTH-1]) begin
      x_nxt = $signed(cell_in.x) - ys;
      y_nxt = $signed(cell_in.y) + xs;
      z_nxt = $signed(cell_in.z) - $signed(atan);
    end else begin
      x_nxt = $signed(cell_in.x) + ys;
      y_nxt = $signed(cell_in.y) - xs;
      z_nxt = $signed(cell_in.z) + $signed(atan);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= cell_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      last_r <= cell_in.last;
    end
  end

  assign cell_out = '{vld: vld_r, x: x_r, y: y_r, z: z_r, last: last_r};

endmodule

// ===== sv/visibility_phase_rotate.sv =====
// visibility_phase_rotate: top level of the visibility phase rotator.
// Uses vpr_pkg, vpr_in_if, vpr_out_if, vpr_phase and vpr_cordic_cell.
//
// Usage:
//  in_ch carries one visibility per request: u, v, w and a complex amplitude
//  with a last flag. out_ch returns the amplitude rotated by the phase
//  u*offset_l + v*offset_m + w*offset_n (turns, fraction only), rounded and
//  saturated, with last copied through. One result per request, in order.
//  cfg_we/cfg_idx/cfg_wdata write the three offsets; index 3 is ignored.
//  Write them only while no request is in flight.
//  Throughput: one request per cycle while out_ch keeps taking results, through
//  a fully pipelined chain of CORDIC_STAGES rotation cells behind three
//  front-end stages. An accepted request passes those stages, the rotation
//  cells and the output register before it shows on out_ch.
//  Reset (rst_n low, synchronous) empties the pipeline and clears the
//  offsets to zero.
//  When out_ch stalls, one more result is caught in a skid register and the
//  whole pipeline then holds; in_ch.ready drops until the skid drains.

module visibility_phase_rotate (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [vpr_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [vpr_pkg::OFFSET_WIDTH-1:0]      cfg_wdata,
  vpr_in_if.sink                                in_ch,
  vpr_out_if.source                             out_ch
);

  logic signed [vpr_pkg::OFFSET_WIDTH-1:0] off_l_r, off_m_r, off_n_r;

  vpr_pkg::cordic_t               chain [vpr_pkg::CORDIC_STAGES+1];
  logic [vpr_pkg::CORDIC_STAGES-1:0] cell_vld;

  logic              pipe_en;
  logic              push;
  logic              take;
  vpr_pkg::vpr_out_t res;

  logic              out_vld_r, out_vld_nxt;
  vpr_pkg::vpr_out_t out_data_r, out_data_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  vpr_pkg::vpr_out_t skid_data_r, skid_data_nxt;

  function automatic logic signed [vpr_pkg::AMP_WIDTH-1:0] round_sat(
    input logic signed [vpr_pkg::XW-1:0] v
  );
    logic signed [vpr_pkg::XW-1:0] r;
    r = (v + vpr_pkg::RND_HALF) >>> vpr_pkg::GUARD;
    if (r > vpr_pkg::SAT_HI) begin
      r = vpr_pkg::SAT_HI;
    end else if (r < vpr_pkg::SAT_LO) begin
      r = vpr_pkg::SAT_LO;
    end
    return r[vpr_pkg::AMP_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_l_r <= '0;
      off_m_r <= '0;
      off_n_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        vpr_pkg::CFG_OFFSET_L: off_l_r <= cfg_wdata;
        vpr_pkg::CFG_OFFSET_M: off_m_r <= cfg_wdata;
        vpr_pkg::CFG_OFFSET_N: off_n_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipeline moves together; only a full skid register stops it
  assign pipe_en     = !skid_vld_r;
  assign in_ch.ready = pipe_en;

  vpr_phase u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_vld    (in_ch.valid),
    .in_data   (in_ch.data),
    .offset_l  (off_l_r),
    .offset_m  (off_m_r),
    .offset_n  (off_n_r),
    .stage_out (chain[0])
  );

  for (genvar i = 0; i < vpr_pkg::CORDIC_STAGES; i++) begin : g_cell
    vpr_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .stage_idx (vpr_pkg::STAGE_IDX_W'(i)),
      .cell_in   (chain[i]),
      .cell_out  (chain[i+1])
    );
    assign cell_vld[i] = chain[i+1].vld;
  end

  assign res  = '{rot_re:   round_sat(chain[vpr_pkg::CORDIC_STAGES].x),
                  rot_im:   round_sat(chain[vpr_pkg::CORDIC_STAGES].y),
                  last_out: chain[vpr_pkg::CORDIC_STAGES].last};
  assign push = pipe_en && chain[vpr_pkg::CORDIC_STAGES].vld;
  assign take = out_vld_r && out_ch.ready;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    skid_vld_nxt  = skid_vld_r;
    skid_data_nxt = skid_data_r;
    if (!out_vld_r || take) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = skid_data_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt  = push;
        out_data_nxt = res;
      end
    end else if (push) begin
      skid_vld_nxt  = 1'b1;
      skid_data_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

  // skid only fills behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register holds a result while output is empty");

  // a full skid freezes the rotation chain
  a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |=> $stable(cell_vld))
    else $error("rotation chain moved while skid register was full");

  // a taken output with a full skid is refilled from the skid
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && take) |=> (out_vld_r && !skid_vld_r))
    else $error("skid register did not drain into the output");

endmodule

// ===== verif/visibility_phase_rotate_tb.sv =====
// visibility_phase_rotate_tb: self-checking bench for the visibility phase rotator.
// Needs vpr_pkg, vpr_in_if, vpr_out_if and visibility_phase_rotate; predicts each
// rotated amplitude in plain integer arithmetic and compares in request order.

module visibility_phase_rotate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vpr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic signed [AMP_WIDTH-1:0] AMP_MAX = {1'b0, {(AMP_WIDTH-1){1'b1}}};
  localparam logic signed [AMP_WIDTH-1:0] AMP_MIN = {1'b1, {(AMP_WIDTH-1){1'b0}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [OFFSET_WIDTH-1:0] OFS_MAX = 32'h7FFF_FFFF;
  localparam logic [OFFSET_WIDTH-1:0] OFS_MIN = 32'h8000_0000;
  localparam logic [OFFSET_WIDTH-1:0] OFS_ONE = 32'h4000_0000;
  localparam int PHASE_COUNT      = 8;
  localparam int ITEMS_PER_PHASE  = 112;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx   = '0;
  logic [OFFSET_WIDTH-1:0] cfg_wdata = '0;

  vpr_in_if  in_ch ();
  vpr_out_if out_ch ();

  // offsets as the block should hold them
  logic signed [OFFSET_WIDTH-1:0] shift_l = '0;
  logic signed [OFFSET_WIDTH-1:0] shift_m = '0;
  logic signed [OFFSET_WIDTH-1:0] shift_n = '0;

  vpr_in_t  visibility_q [$];
  vpr_out_t rotated_q [$];
  int       mismatch_count = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;

  visibility_phase_rotate u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  function automatic logic signed [AMP_WIDTH-1:0] clamp_amp(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (AMP_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return AMP_WIDTH'(v);
  endfunction

  function automatic vpr_out_t rotate_visibility(input vpr_in_t vis);
    logic [63:0] acc;
    logic [PHASE_WIDTH-1:0] phase;
    logic [PHASE_WIDTH-1:0] biased;
    logic [PHASE_WIDTH-1:0] resid;
    logic [1:0] quad;
    longint x, y, z, t, xs, ys;
    vpr_out_t res;
    // phase sum wraps modulo 2^64, fraction bits below the binary point
    acc = longint'($signed(vis.coord_u)) * longint'(shift_l)
        + longint'($signed(vis.coord_v)) * longint'(shift_m)
        + longint'($signed(vis.coord_w)) * longint'(shift_n);
    phase  = acc[PHASE_FB-1 -: PHASE_WIDTH];
    biased = phase + 32'h2000_0000;
    quad   = biased[31:30];
    resid  = phase - {quad, 30'b0};
    z = longint'($signed(resid));
    x = longint'($signed(vis.amp_re));
    y = longint'($signed(vis.amp_im));
    case (quad)
      QUAD_ONE: begin
        t = x; x = -y; y = t;
      end
      QUAD_TWO: begin
        x = -x; y = -y;
      end
      QUAD_THREE: begin
        t = x; x = y; y = -t;
      end
      default: ;
    endcase
    x = (x * longint'(KINV_Q30)) >>> GAIN_SHIFT;
    y = (y * longint'(KINV_Q30)) >>> GAIN_SHIFT;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TURNS[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TURNS[i]);
      end
    end
    res.rot_re   = clamp_amp((x + (longint'(1) <<< (GUARD - 1))) >>> GUARD);
    res.rot_im   = clamp_amp((y + (longint'(1) <<< (GUARD - 1))) >>> GUARD);
    res.last_out = vis.last_in;
    return res;
  endfunction

  function automatic vpr_in_t make_vis(input logic [COORD_WIDTH-1:0] u,
                                       input logic [COORD_WIDTH-1:0] v,
                                       input logic [COORD_WIDTH-1:0] w,
                                       input logic [AMP_WIDTH-1:0] re,
                                       input logic [AMP_WIDTH-1:0] im,
                                       input logic last);
    vpr_in_t vis;
    vis.coord_u = u;
    vis.coord_v = v;
    vis.coord_w = w;
    vis.amp_re  = re;
    vis.amp_im  = im;
    vis.last_in = last;
    return vis;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] random_coord();
    case ($urandom_range(7))
      0:       return COORD_WIDTH'($urandom_range(131072)) - COORD_WIDTH'(65536);
      1:       return COORD_MAX;
      2:       return COORD_MIN;
      default: return COORD_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [AMP_WIDTH-1:0] random_amp();
    case ($urandom_range(9))
      0:       return AMP_MAX;
      1:       return AMP_MIN;
      default: return AMP_WIDTH'($urandom);
    endcase
  endfunction

  function automatic vpr_in_t random_visibility();
    return make_vis(random_coord(), random_coord(), random_coord(),
                    random_amp(), random_amp(), $urandom_range(7) == 0);
  endfunction

  task automatic write_offset(input logic [CFG_IDX_W-1:0] idx,
                              input logic [OFFSET_WIDTH-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OFFSET_L: shift_l = value;
      CFG_OFFSET_M: shift_m = value;
      CFG_OFFSET_N: shift_n = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_offsets(input logic [OFFSET_WIDTH-1:0] l,
                             input logic [OFFSET_WIDTH-1:0] m,
                             input logic [OFFSET_WIDTH-1:0] n);
    write_offset(CFG_OFFSET_L, l);
    write_offset(CFG_OFFSET_M, m);
    write_offset(CFG_OFFSET_N, n);
  endtask

  task automatic wait_drained();
    while (visibility_q.size() != 0 || in_ch.valid || rotated_q.size() != 0)
      @(negedge clk);
  endtask

  always @(posedge clk) begin : request_driver
    logic taken;
    taken = in_ch.valid && in_ch.ready;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (taken) begin
        rotated_q.push_back(rotate_visibility(in_ch.data));
        void'(visibility_q.pop_front());
      end
      if (in_ch.valid && !taken) begin
        // request stays up until accepted
      end else if (visibility_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= visibility_q[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    vpr_out_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (rotated_q.size() == 0) begin
          $error("result with no request outstanding: rot_re %0d rot_im %0d",
                 out_ch.data.rot_re, out_ch.data.rot_im);
          mismatch_count++;
        end else begin
          want = rotated_q.pop_front();
          if (out_ch.data.rot_re !== want.rot_re) begin
            $error("rot_re: expected %0d, got %0d", want.rot_re, out_ch.data.rot_re);
            mismatch_count++;
          end
          if (out_ch.data.rot_im !== want.rot_im) begin
            $error("rot_im: expected %0d, got %0d", want.rot_im, out_ch.data.rot_im);
            mismatch_count++;
          end
          if (out_ch.data.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, out_ch.data.last_out);
            mismatch_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : stimulus
    logic [OFFSET_WIDTH-1:0] l_val, m_val, n_val;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // offsets still at reset: zero phase, amplitude extremes
    visibility_q.push_back(make_vis('0, '0, '0, AMP_MAX, AMP_MAX, 1'b0));
    visibility_q.push_back(make_vis(COORD_MAX, COORD_MIN, COORD_MAX, AMP_MIN, AMP_MIN, 1'b1));
    visibility_q.push_back(make_vis('0, '0, '0, AMP_MIN, AMP_MAX, 1'b0));
    visibility_q.push_back(make_vis('0, '0, '0, '0, '0, 1'b1));
    wait_drained();

    // unused index must leave the offsets alone; then one turn per wavelength in l
    write_offset(CFG_UNUSED, 32'hFFFF_FFFF);
    set_offsets(OFS_ONE, '0, '0);
    visibility_q.push_back(make_vis(32'h0000_4000, '0, '0, AMP_MAX, '0, 1'b0));
    visibility_q.push_back(make_vis(32'h0000_8000, '0, '0, AMP_MAX, '0, 1'b0));
    visibility_q.push_back(make_vis(32'h0000_C000, '0, '0, AMP_MAX, '0, 1'b1));
    // eighth turns: full scale grows past the output range
    visibility_q.push_back(make_vis(32'h0000_2000, '0, '0, AMP_MAX, AMP_MAX, 1'b0));
    visibility_q.push_back(make_vis(32'h0000_6000, '0, '0, AMP_MIN, AMP_MIN, 1'b0));
    visibility_q.push_back(make_vis(32'h0000_E000, '0, '0, AMP_MIN, AMP_MAX, 1'b1));
    // integer turns wrap away
    visibility_q.push_back(make_vis(COORD_MAX, '0, '0, AMP_MAX, AMP_MIN, 1'b0));
    visibility_q.push_back(make_vis(COORD_MIN, '0, '0, AMP_MIN, '0, 1'b0));
    wait_drained();

    set_offsets(OFS_MAX, OFS_MIN, OFS_MAX);
    visibility_q.push_back(make_vis(COORD_MAX, COORD_MAX, COORD_MAX, AMP_MAX, AMP_MIN, 1'b0));
    visibility_q.push_back(make_vis(COORD_MIN, COORD_MIN, COORD_MIN, AMP_MIN, AMP_MAX, 1'b1));
    visibility_q.push_back(make_vis(COORD_MAX, COORD_MIN, COORD_MAX, random_amp(), random_amp(),
                                    1'b0));
    visibility_q.push_back(make_vis(COORD_MIN, COORD_MAX, COORD_MIN, random_amp(), random_amp(),
                                    1'b1));

    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_drained();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      case (p)
        1: begin l_val = OFS_MAX; m_val = OFS_MAX; n_val = OFS_MAX; end
        2: begin l_val = OFS_MIN; m_val = OFS_MIN; n_val = OFS_MIN; end
        3: begin
          // small shifts keep the phase near zero
          l_val = 32'($urandom_range(4096)) - 32'd2048;
          m_val = 32'($urandom_range(4096)) - 32'd2048;
          n_val = 32'($urandom_range(4096)) - 32'd2048;
        end
        6: begin l_val = '0; m_val = '0; n_val = '0; end
        default: begin l_val = $urandom; m_val = $urandom; n_val = $urandom; end
      endcase
      set_offsets(l_val, m_val, n_val);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // sender holds off mid-phase until the pipeline has emptied
        if (k == ITEMS_PER_PHASE / 2) wait_drained();
        visibility_q.push_back(random_visibility());
      end
    end

    wait_drained();
    repeat (CORDIC_STAGES + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #1ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
